### sv/wfn_pkg.sv
// Shared types and constants for the wall follower navigator.
package wfn_pkg;

    // Fixed field widths of the request and result channels
    localparam int POS_W  = 4;
    localparam int HEAD_W = 2;
    localparam int WALL_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Default maze side and goal corner
    localparam int MAZE_SIDE_DEF = 16;
    localparam logic [POS_W-1:0] GOAL_RESET = 4'd15;

    // Result commands
    typedef enum logic [1:0] {
        CMD_LEFT  = 2'd0,
        CMD_RIGHT = 2'd1,
        CMD_MOVE  = 2'd2,
        CMD_GOAL  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y      = 2'd2;

    // Heading step for one quarter turn, right (+1) or left (-1)
    function automatic logic [HEAD_W-1:0] turn_step(input logic right);
        return right ? 2'd1 : 2'd3;
    endfunction

endpackage

### sv/wfn_wall_map.sv
// Wall map memory: registered read, write-first forwarding, clearing pass after reset.
module wfn_wall_map
    import wfn_pkg::*;
#(
    parameter int MAZE_SIDE = MAZE_SIDE_DEF,
    localparam int DEPTH  = MAZE_SIDE * MAZE_SIDE,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WALL_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WALL_W-1:0] wr_data,
    output logic              busy
);

    logic [WALL_W-1:0] mem [DEPTH];
    logic [WALL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    // Clearing sweep, one entry per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // Write port, shared between the sweep and the merge write-back
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle wins
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

### sv/wall_follower_navigator_core.sv
// Top level of the wall follower navigator: pose tracking, map merge and command sequencing.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  s        | in        | s_valid / s_ready     | s_sense_left, s_sense_front, s_sense_right
//  m        | out       | m_valid / m_ready     | m_command, m_pos_x, m_pos_y, m_heading,
//           |           |                       | m_cell_walls, m_last
//
// A request gives 1 to 3 results; the result register emits one per cycle while m_ready is high
// and takes the next request only as the last result of the current one leaves, so a request
// with n results holds the pipe until all n have left; single-result requests run back to back,
// one per cycle while m_ready is high. The first result passes through the merge stage into
// the result register: the map is read as the request is taken, and merge and write-back
// follow as the merge stage moves on. After reset every map entry is swept clear with s_ready
// low; configuration writes are taken throughout. A stalled m channel backs up into the merge
// stage and then drops s_ready.
module wall_follower_navigator_core
    import wfn_pkg::*;
#(
    parameter int MAZE_SIDE = MAZE_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_sense_left,
    input  logic                  s_sense_front,
    input  logic                  s_sense_right,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_command,
    output logic [POS_W-1:0]      m_pos_x,
    output logic [POS_W-1:0]      m_pos_y,
    output logic [HEAD_W-1:0]     m_heading,
    output logic [WALL_W-1:0]     m_cell_walls,
    output logic                  m_last
);

    localparam int DEPTH  = MAZE_SIDE * MAZE_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = $clog2(MAZE_SIDE);
    localparam int CW     = (PW > POS_W) ? PW : POS_W;

    function automatic logic [PW-1:0] step_up(input logic [PW-1:0] v);
        return (v == PW'(MAZE_SIDE - 1)) ? '0 : v + PW'(1);
    endfunction

    function automatic logic [PW-1:0] step_down(input logic [PW-1:0] v);
        return (v == '0) ? PW'(MAZE_SIDE - 1) : v - PW'(1);
    endfunction

    // Configuration registers
    logic             follow_side_reg;
    logic [POS_W-1:0] goal_x_reg;
    logic [POS_W-1:0] goal_y_reg;

    // Robot pose, advanced when a request is taken
    logic [PW-1:0]     robot_x_reg;
    logic [PW-1:0]     robot_y_reg;
    logic [HEAD_W-1:0] robot_heading_reg;

    // Merge stage (waits on the map read)
    logic              b_valid_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [WALL_W-1:0] b_add_reg;
    logic              b_goal_reg;
    logic              b_dir_reg;
    logic [1:0]        b_nturn_reg;
    logic [PW-1:0]     b_x_pre_reg;
    logic [PW-1:0]     b_y_pre_reg;
    logic [PW-1:0]     b_x_fin_reg;
    logic [PW-1:0]     b_y_fin_reg;
    logic [HEAD_W-1:0] b_h1_reg;
    logic [HEAD_W-1:0] b_h_fin_reg;

    // Result register and the rest of the command sequence
    logic              m_valid_reg;
    cmd_t              m_command_reg;
    logic [PW-1:0]     e_x_reg;
    logic [PW-1:0]     e_y_reg;
    logic [HEAD_W-1:0] m_heading_reg;
    logic [WALL_W-1:0] m_cell_walls_reg;
    logic              m_last_reg;
    logic              e_dir_reg;
    logic              e_turn_rem_reg;
    logic [PW-1:0]     e_x_fin_reg;
    logic [PW-1:0]     e_y_fin_reg;
    logic [HEAD_W-1:0] e_h_fin_reg;

    logic              map_busy;
    logic [WALL_W-1:0] map_rd_data;
    logic [WALL_W-1:0] merged;
    logic              s_fire;
    logic              e_free;
    logic              b_move;

    // Request-side planning
    logic [ADDR_W-1:0] a_addr;
    logic [WALL_W-1:0] a_add;
    logic              a_goal;
    logic              a_near_open;
    logic              a_far_open;
    logic              a_dir;
    logic [1:0]        a_nturn;
    logic [HEAD_W-1:0] a_step;
    logic [HEAD_W-1:0] a_h1;
    logic [HEAD_W-1:0] a_h_fin;
    logic [PW-1:0]     a_x_fin;
    logic [PW-1:0]     a_y_fin;

    assign e_free  = !m_valid_reg || (m_ready && m_last_reg);
    assign b_move  = b_valid_reg && e_free;
    assign s_ready = !map_busy && (!b_valid_reg || b_move);
    assign s_fire  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign merged  = map_rd_data | b_add_reg;

    // Map memory
    wfn_wall_map #(
        .MAZE_SIDE (MAZE_SIDE)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (a_addr),
        .rd_data (map_rd_data),
        .wr_en   (b_move),
        .wr_addr (b_addr_reg),
        .wr_data (merged),
        .busy    (map_busy)
    );

    // Absolute wall bits, goal check and the left/right-hand rule
    always_comb begin
        a_addr = ADDR_W'(ADDR_W'(robot_x_reg) * ADDR_W'(MAZE_SIDE) + ADDR_W'(robot_y_reg));
        a_add = '0;
        if (s_sense_front) a_add[robot_heading_reg] = 1'b1;
        if (s_sense_right) a_add[robot_heading_reg + 2'd1] = 1'b1;
        if (s_sense_left)  a_add[robot_heading_reg + 2'd3] = 1'b1;
        a_goal = (CW'(robot_x_reg) == CW'(goal_x_reg)) && (CW'(robot_y_reg) == CW'(goal_y_reg));
        a_near_open = follow_side_reg ? !s_sense_right : !s_sense_left;
        a_far_open  = follow_side_reg ? !s_sense_left  : !s_sense_right;
        a_dir   = follow_side_reg;
        a_nturn = 2'd0;
        priority if (a_goal) begin
            a_nturn = 2'd0;
        end else if (a_near_open) begin
            a_nturn = 2'd1;
        end else if (!s_sense_front) begin
            a_nturn = 2'd0;
        end else if (a_far_open) begin
            a_dir   = !follow_side_reg;
            a_nturn = 2'd1;
        end else begin
            a_nturn = 2'd2;
        end
        a_step = turn_step(a_dir);
        a_h1   = robot_heading_reg + a_step;
        unique case (a_nturn)
            2'd0:    a_h_fin = robot_heading_reg;
            2'd1:    a_h_fin = a_h1;
            default: a_h_fin = a_h1 + a_step;
        endcase
        a_x_fin = robot_x_reg;
        a_y_fin = robot_y_reg;
        if (!a_goal) begin
            unique case (a_h_fin)
                2'd0:    a_y_fin = step_up(robot_y_reg);
                2'd1:    a_x_fin = step_up(robot_x_reg);
                2'd2:    a_y_fin = step_down(robot_y_reg);
                default: a_x_fin = step_down(robot_x_reg);
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_side_reg <= 1'b0;
            goal_x_reg      <= GOAL_RESET;
            goal_y_reg      <= GOAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FOLLOW_SIDE: follow_side_reg <= cfg_data[0];
                CFG_GOAL_X:      goal_x_reg      <= cfg_data;
                CFG_GOAL_Y:      goal_y_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pose update and merge stage load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            robot_x_reg       <= '0;
            robot_y_reg       <= '0;
            robot_heading_reg <= '0;
            b_valid_reg       <= 1'b0;
        end else begin
            if (s_fire) begin
                robot_x_reg       <= a_x_fin;
                robot_y_reg       <= a_y_fin;
                robot_heading_reg <= a_h_fin;
                b_valid_reg       <= 1'b1;
            end else if (b_move) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            b_addr_reg  <= a_addr;
            b_add_reg   <= a_add;
            b_goal_reg  <= a_goal;
            b_dir_reg   <= a_dir;
            b_nturn_reg <= a_nturn;
            b_x_pre_reg <= robot_x_reg;
            b_y_pre_reg <= robot_y_reg;
            b_x_fin_reg <= a_x_fin;
            b_y_fin_reg <= a_y_fin;
            b_h1_reg    <= a_h1;
            b_h_fin_reg <= a_h_fin;
        end
    end

    // Result sequencing: turns first, then the move; goal gives a single result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready && m_last_reg) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            m_cell_walls_reg <= merged;
            e_dir_reg        <= b_dir_reg;
            e_x_fin_reg      <= b_x_fin_reg;
            e_y_fin_reg      <= b_y_fin_reg;
            e_h_fin_reg      <= b_h_fin_reg;
            e_turn_rem_reg   <= (b_nturn_reg == 2'd2);
            priority if (b_goal_reg) begin
                m_command_reg <= CMD_GOAL;
                e_x_reg       <= b_x_fin_reg;
                e_y_reg       <= b_y_fin_reg;
                m_heading_reg <= b_h_fin_reg;
                m_last_reg    <= 1'b1;
            end else if (b_nturn_reg != 2'd0) begin
                m_command_reg <= b_dir_reg ? CMD_RIGHT : CMD_LEFT;
                e_x_reg       <= b_x_pre_reg;
                e_y_reg       <= b_y_pre_reg;
                m_heading_reg <= b_h1_reg;
                m_last_reg    <= 1'b0;
            end else begin
                m_command_reg <= CMD_MOVE;
                e_x_reg       <= b_x_fin_reg;
                e_y_reg       <= b_y_fin_reg;
                m_heading_reg <= b_h_fin_reg;
                m_last_reg    <= 1'b1;
            end
        end else if (m_valid_reg && m_ready && !m_last_reg) begin
            if (e_turn_rem_reg) begin
                m_heading_reg  <= m_heading_reg + turn_step(e_dir_reg);
                e_turn_rem_reg <= 1'b0;
            end else begin
                m_command_reg <= CMD_MOVE;
                e_x_reg       <= e_x_fin_reg;
                e_y_reg       <= e_y_fin_reg;
                m_heading_reg <= e_h_fin_reg;
                m_last_reg    <= 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_command    = m_command_reg;
    assign m_pos_x      = POS_W'(CW'(e_x_reg));
    assign m_pos_y      = POS_W'(CW'(e_y_reg));
    assign m_heading    = m_heading_reg;
    assign m_cell_walls = m_cell_walls_reg;
    assign m_last       = m_last_reg;

    // Goal and move results always close a request
    a_goal_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_command_reg == CMD_GOAL || m_command_reg == CMD_MOVE) |-> m_last)
        else $error("goal or move result not marked last");

    // A taken non-final result is followed by the next one of the same request
    a_burst_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("result sequence broken off");

    // No request is taken while the map is being cleared
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        map_busy |-> !s_ready)
        else $error("request taken during map clearing");

    // A stalled merge stage keeps its address until it moves on
    a_b_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_move |=> b_valid_reg && $stable(b_addr_reg))
        else $error("merge stage lost its request");

    // Turn results keep the position of the sensed cell
    a_turn_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last && e_turn_rem_reg |=> $stable(e_x_reg) && $stable(e_y_reg))
        else $error("position changed between turns");

endmodule
